### hdl/mavt_pkg.sv
package mavt_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_WRAP_THRESHOLD   = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_US     = 2'd1;
  localparam logic [1:0] CFG_MAX_INTERVAL     = 2'd2;
  localparam logic [1:0] CFG_FALLBACK_INTERVAL = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Reset values of the configuration registers.
  localparam logic [14:0] WRAP_THRESHOLD_RST    = 15'd26214;
  localparam logic [7:0]  TICKS_PER_US_RST      = 8'd9;
  localparam logic [23:0] MAX_INTERVAL_RST      = 24'd4500000;
  localparam logic [23:0] FALLBACK_INTERVAL_RST = 24'd9000;

  // Opcodes of an input word.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ANGLE = 2'd1;
  localparam logic [1:0] OP_VEL   = 2'd2;

  // Defaults of the top-level parameters.
  localparam int COUNTS_PER_TURN_DEFAULT = 32768;
  localparam int TIMER_WIDTH_DEFAULT     = 24;

  // Fixed widths of the datapath.
  localparam int RAW_W   = 15;
  localparam int TURNS_W = 32;
  localparam int POS_W   = 48;
  localparam int VEL_W   = 32;
  localparam int DIV_W   = 32;  // divisor width, covers the widest timer and the 24-bit registers
  localparam int K_W     = 28;  // ticks per microsecond times one million
  localparam logic [19:0] TICKS_SCALE = 20'd1000000;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [14:0] wrap_threshold;
    logic [7:0]  ticks_per_us;
    logic [23:0] max_interval;
    logic [23:0] fallback_interval;
  } cfg_t;

  // One classified and unwrapped word, handed from the front to the back.
  typedef struct packed {
    logic                vel;
    logic                neg;
    logic                fb;
    logic [POS_W-1:0]    mag;
    logic [DIV_W-1:0]    div_e;
    logic [TURNS_W-1:0]  turns;
    logic [POS_W-1:0]    pos;
  } job_t;

endpackage

### hdl/mavt_if.sv
interface mavt_in_if #(
  parameter int TIMER_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [14:0]            raw_angle;
  logic [TIMER_WIDTH-1:0] tick_time;

  modport source (output valid, opcode, raw_angle, tick_time, input ready);
  modport sink (input valid, opcode, raw_angle, tick_time, output ready);
endinterface

interface mavt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] turn_count;
  logic signed [47:0] position;
  logic signed [31:0] velocity;
  logic               velocity_valid;
  logic               interval_fallback;

  modport source (output valid, turn_count, position, velocity, velocity_valid,
                  interval_fallback, input ready);
  modport sink (input valid, turn_count, position, velocity, velocity_valid,
                interval_fallback, output ready);
endinterface

### hdl/multiturn_angle_velocity_tracker_top.sv
// Multi-turn angle tracker with velocity estimate.
// Input words arrive on in_ch (opcode, raw_angle, tick_time) and are taken when
// valid and ready are both high; one result word leaves on out_ch for every input
// word, in order, with the same handshake. Configuration registers are written
// through cfg_we, cfg_index and cfg_data, one register per clock; the user must
// write them only while the block is idle, and the block does not enforce this.
// The front stage takes a new word only after handing the last one on: it unwraps
// the angle, works out the elapsed ticks and the position change, and hands the
// word to a two-entry queue. The back stage passes an init or angle word straight
// to its output register; a velocity word is scaled by the tick rate and then goes
// through the shift-and-subtract divider that produces one quotient bit per cycle;
// when the quotient is bound to saturate the divider is skipped. The back stage
// takes a new word only after loading the last one into the output register.
// Synchronous reset returns the registers to their default values, clears the
// turn count, the stored sample and both velocity references, and empties the
// queue and the output register.
// While the receiver holds ready low, the finished word waits in the output
// register; the back stage stops, then the queue fills and the front stalls.
module multiturn_angle_velocity_tracker_top
  import mavt_pkg::*;
#(
  parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEFAULT,
  parameter int TIMER_WIDTH     = TIMER_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mavt_in_if.sink                in_ch,
  mavt_out_if.source             out_ch
);

  // The configuration registers are shared by the front and the back stage.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_threshold    <= WRAP_THRESHOLD_RST;
      cfg.ticks_per_us      <= TICKS_PER_US_RST;
      cfg.max_interval      <= MAX_INTERVAL_RST;
      cfg.fallback_interval <= FALLBACK_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRAP_THRESHOLD:    cfg.wrap_threshold    <= cfg_data[14:0];
        CFG_TICKS_PER_US:      cfg.ticks_per_us      <= cfg_data[7:0];
        CFG_MAX_INTERVAL:      cfg.max_interval      <= cfg_data[23:0];
        CFG_FALLBACK_INTERVAL: cfg.fallback_interval <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // Words travel from the front stage through the queue to the back stage.
  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic back_valid;
  logic back_ready;
  job_t back_job;

  mavt_front #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .TIMER_WIDTH     (TIMER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  mavt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_job)
  );

  mavt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job_in    (back_job),
    .out_ch    (out_ch)
  );

  // A velocity word with the references just cleared by init still divides by a
  // non-zero interval, so the fallback flag may only appear with a velocity.
  a_fb_needs_vel: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.interval_fallback) |-> out_ch.velocity_valid)
    else $error("fallback flag without a velocity estimate");

endmodule

### hdl/mavt_front.sv
module mavt_front
  import mavt_pkg::*;
#(
  parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEFAULT,
  parameter int TIMER_WIDTH     = TIMER_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  mavt_in_if.sink       in_ch,
  output logic          job_valid,
  input  logic          job_ready,
  output job_t          job
);

  localparam logic [2:0] FS_IDLE   = 3'd0;
  localparam logic [2:0] FS_UNWRAP = 3'd1;
  localparam logic [2:0] FS_POS    = 3'd2;
  localparam logic [2:0] FS_DELTA  = 3'd3;
  localparam logic [2:0] FS_PUSH   = 3'd4;

  localparam logic [POS_W-1:0] CPT = POS_W'(COUNTS_PER_TURN);

  logic [2:0]             fs;
  logic                   do_init;
  logic                   do_vel;
  logic [RAW_W-1:0]       raw;
  logic [TIMER_WIDTH-1:0] now;
  logic [RAW_W-1:0]       last_raw;
  logic [TURNS_W-1:0]     turns;
  logic [TIMER_WIDTH-1:0] ref_time;
  logic [POS_W-1:0]       ref_pos;
  logic [TIMER_WIDTH-1:0] elapsed;
  logic [DIV_W-1:0]       div_e;
  logic                   fb;
  logic [POS_W-1:0]       pos;
  logic [POS_W:0]         delta;

  logic [RAW_W:0]         d;
  logic [RAW_W:0]         d_mag;
  logic                   wrap;
  logic [TIMER_WIDTH-1:0] elapsed_next;
  logic                   too_long;

  assign in_ch.ready = (fs == FS_IDLE);

  always_comb begin
    d     = {1'b0, raw} - {1'b0, last_raw};
    d_mag = d[RAW_W] ? (RAW_W+1)'(0) - d : d;
    wrap  = d_mag > {1'b0, cfg.wrap_threshold};
    if (now < ref_time) begin
      elapsed_next = ref_time - now;
    end else begin
      elapsed_next = ~now + ref_time;
    end
    too_long = (elapsed == '0) || (DIV_W'(elapsed) > DIV_W'(cfg.max_interval));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs       <= FS_IDLE;
      last_raw <= '0;
      turns    <= '0;
      ref_time <= '0;
      ref_pos  <= '0;
    end else begin
      case (fs)
        FS_IDLE: begin
          if (in_ch.valid) begin
            do_init <= (in_ch.opcode == OP_INIT);
            do_vel  <= (in_ch.opcode == OP_VEL);
            raw     <= in_ch.raw_angle;
            now     <= in_ch.tick_time;
            fs      <= FS_UNWRAP;
          end
        end
        FS_UNWRAP: begin
          elapsed  <= elapsed_next;
          last_raw <= raw;
          if (do_init) begin
            turns    <= '0;
            ref_time <= '0;
          end else begin
            if (wrap) begin
              if (!d[RAW_W]) begin
                if (turns != {1'b1, {(TURNS_W-1){1'b0}}}) begin
                  turns <= turns - 1'b1;
                end
              end else begin
                if (turns != {1'b0, {(TURNS_W-1){1'b1}}}) begin
                  turns <= turns + 1'b1;
                end
              end
            end
            if (do_vel) begin
              ref_time <= now;
            end
          end
          fs <= FS_POS;
        end
        FS_POS: begin
          pos <= {{(POS_W-TURNS_W){turns[TURNS_W-1]}}, turns} * CPT
                 + {{(POS_W-RAW_W){1'b0}}, last_raw};
          if (do_vel && too_long) begin
            fb    <= 1'b1;
            div_e <= (cfg.fallback_interval == '0) ? DIV_W'(1)
                                                   : DIV_W'(cfg.fallback_interval);
          end else begin
            fb    <= 1'b0;
            div_e <= do_vel ? DIV_W'(elapsed) : DIV_W'(1);
          end
          fs <= FS_DELTA;
        end
        FS_DELTA: begin
          delta <= {pos[POS_W-1], pos} - {ref_pos[POS_W-1], ref_pos};
          if (do_init || do_vel) begin
            ref_pos <= pos;
          end
          fs <= FS_PUSH;
        end
        FS_PUSH: begin
          if (job_ready) begin
            fs <= FS_IDLE;
          end
        end
        default: begin
          fs <= FS_IDLE;
        end
      endcase
    end
  end

  logic [POS_W:0] delta_neg;
  assign delta_neg = (POS_W+1)'(0) - delta;

  assign job_valid = (fs == FS_PUSH);
  always_comb begin
    job.vel   = do_vel;
    job.neg   = delta[POS_W];
    job.fb    = fb;
    job.mag   = delta[POS_W] ? delta_neg[POS_W-1:0] : delta[POS_W-1:0];
    job.div_e = div_e;
    job.turns = turns;
    job.pos   = pos;
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (fs == FS_PUSH) |-> (div_e != '0))
    else $error("front hands on a zero divisor");

endmodule

### hdl/mavt_queue.sv
module mavt_queue
  import mavt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_fire;
  logic             rd_fire;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_fire && !rd_fire) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

### hdl/mavt_back.sv
module mavt_back
  import mavt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     job_valid,
  output logic     job_ready,
  input  job_t     job_in,
  mavt_out_if.source out_ch
);

  localparam logic [3:0] BS_IDLE = 4'd0;
  localparam logic [3:0] BS_K    = 4'd1;
  localparam logic [3:0] BS_MLO  = 4'd2;
  localparam logic [3:0] BS_MHI  = 4'd3;
  localparam logic [3:0] BS_SUM  = 4'd4;
  localparam logic [3:0] BS_CHK  = 4'd5;
  localparam logic [3:0] BS_DIV  = 4'd6;
  localparam logic [3:0] BS_OUT  = 4'd7;

  localparam int HALF_W = POS_W / 2;
  localparam int PP_W   = HALF_W + K_W;
  localparam int NUM_W  = POS_W + K_W;
  localparam int HI_W   = NUM_W - VEL_W;
  localparam int CNT_W  = $clog2(VEL_W);

  logic [3:0]       bs;
  job_t             job;
  logic [K_W-1:0]   k;
  logic [PP_W-1:0]  plo;
  logic [PP_W-1:0]  phi;
  logic [NUM_W-1:0] num;
  logic [DIV_W-1:0] rem;
  logic [VEL_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             sat;

  logic             out_valid;
  logic             out_load;
  logic [DIV_W:0]   trial;
  logic             trial_ge;
  logic [VEL_W-1:0] res;
  logic [VEL_W-1:0] vel_value;

  localparam logic [VEL_W-1:0] VEL_MIN_MAG = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [VEL_W-1:0] VEL_MAX     = {1'b0, {(VEL_W-1){1'b1}}};

  assign job_ready = (bs == BS_IDLE);
  assign out_load  = (bs == BS_OUT) && (!out_valid || out_ch.ready);

  always_comb begin
    trial    = {rem, quo[VEL_W-1]};
    trial_ge = trial >= {1'b0, job.div_e};
    if (sat || quo > VEL_MIN_MAG) begin
      res = VEL_MIN_MAG;
    end else begin
      res = quo;
    end
    if (!job.vel) begin
      vel_value = '0;
    end else if (job.neg) begin
      vel_value = VEL_W'(0) - res;
    end else begin
      vel_value = res[VEL_W-1] ? VEL_MAX : res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs <= BS_IDLE;
    end else begin
      case (bs)
        BS_IDLE: begin
          if (job_valid) begin
            job <= job_in;
            bs  <= job_in.vel ? BS_K : BS_OUT;
          end
        end
        BS_K: begin
          k  <= K_W'({20'd0, cfg.ticks_per_us} * {8'd0, TICKS_SCALE});
          bs <= BS_MLO;
        end
        BS_MLO: begin
          plo <= {{K_W{1'b0}}, job.mag[HALF_W-1:0]} * {{HALF_W{1'b0}}, k};
          bs  <= BS_MHI;
        end
        BS_MHI: begin
          phi <= {{K_W{1'b0}}, job.mag[POS_W-1:HALF_W]} * {{HALF_W{1'b0}}, k};
          bs  <= BS_SUM;
        end
        BS_SUM: begin
          num <= {phi, {HALF_W{1'b0}}} + {{(NUM_W-PP_W){1'b0}}, plo};
          bs  <= BS_CHK;
        end
        BS_CHK: begin
          // A top part at or above the divisor means a quotient of 2^32 or more.
          sat <= num[NUM_W-1:VEL_W] >= HI_W'(job.div_e);
          rem <= num[VEL_W+DIV_W-1:VEL_W];
          quo <= num[VEL_W-1:0];
          cnt <= '0;
          bs  <= (num[NUM_W-1:VEL_W] >= HI_W'(job.div_e)) ? BS_OUT : BS_DIV;
        end
        BS_DIV: begin
          rem <= trial_ge ? DIV_W'(trial - {1'b0, job.div_e}) : trial[DIV_W-1:0];
          quo <= {quo[VEL_W-2:0], trial_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(VEL_W - 1)) begin
            bs <= BS_OUT;
          end
        end
        BS_OUT: begin
          if (out_load) begin
            bs <= BS_IDLE;
          end
        end
        default: begin
          bs <= BS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.turn_count        <= job.turns;
      out_ch.position          <= job.pos;
      out_ch.velocity          <= vel_value;
      out_ch.velocity_valid    <= job.vel;
      out_ch.interval_fallback <= job.vel && job.fb;
    end
  end

  assign out_ch.valid = out_valid;

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (bs == BS_DIV) |-> (rem < job.div_e))
    else $error("division remainder not below the divisor");

  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.velocity_valid) |-> (out_ch.velocity == '0)
      && !out_ch.interval_fallback)
    else $error("velocity shown on a word without a velocity estimate");

endmodule

### verif/tb_multiturn_angle_velocity_tracker_top.sv
module tb_multiturn_angle_velocity_tracker_top;
  import mavt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The spare opcode has no name in the package; the block treats it as an angle word.
  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam logic [23:0] TIMER_MAX      = 24'hFFFFFF;
  // Cycles of settling time allowed after the last owed result has come back.
  localparam int          DRAIN_CYCLES   = 60;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] turn_count;
    logic signed [47:0] position;
    logic signed [31:0] velocity;
    logic               velocity_valid;
    logic               interval_fallback;
  } tracker_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mavt_in_if #(.TIMER_WIDTH(TIMER_WIDTH_DEFAULT)) in_ch ();
  mavt_out_if                                     out_ch ();

  multiturn_angle_velocity_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // Our own copy of the configuration registers, updated as each one is written.
  logic [14:0] cfg_wrap;
  logic [7:0]  cfg_tpu;
  logic [23:0] cfg_max_int;
  logic [23:0] cfg_fallback;

  // Tracker state as the block ought to hold it.
  logic [14:0]        last_angle;
  int                 turn_total;
  logic signed [47:0] vel_ref_pos;
  logic [23:0]        vel_ref_tick;

  // Results still owed by the block, oldest first.
  tracker_result_t results_due[$];

  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int          hold_ready_cycles = 0;
  bit          idle_on = 1'b1;

  // A smoothly turning shaft, used to build well-formed random sequences.
  logic [14:0] trk_angle;
  logic [23:0] trk_stamp;
  int          trk_step_max;
  int          trk_dt_max;

  function automatic logic signed [47:0] position_now();
    longint p;
    p = longint'(turn_total) * longint'(COUNTS_PER_TURN_DEFAULT) + longint'(last_angle);
    return p[47:0];
  endfunction

  // A jump larger than the threshold is taken as a full turn in the other direction.
  function automatic void unwrap_angle(input logic [14:0] raw);
    int d;
    int jump;
    d    = int'(raw) - int'(last_angle);
    jump = (d < 0) ? -d : d;
    if (jump > int'(cfg_wrap)) begin
      if (d > 0) begin
        if (turn_total != 32'sh8000_0000) turn_total--;
      end else begin
        if (turn_total != 32'sh7FFF_FFFF) turn_total++;
      end
    end
    last_angle = raw;
  endfunction

  // Works out the result word for one accepted input word and advances the state.
  function automatic tracker_result_t track_sample(input logic [1:0] op, input logic [14:0] raw,
                                                   input logic [23:0] now);
    tracker_result_t   res;
    longint unsigned   elapsed;
    longint unsigned   mag;
    longint unsigned   k;
    longint unsigned   q;
    longint unsigned   r;
    longint unsigned   speed;
    longint            delta;
    res = '0;
    if (op == OP_INIT) begin
      last_angle   = raw;
      turn_total   = 0;
      vel_ref_tick = '0;
      vel_ref_pos  = position_now();
    end else if (op == OP_VEL) begin
      // The timer counts down, so time has passed when the new stamp is lower.
      if (now < vel_ref_tick) begin
        elapsed = 64'(vel_ref_tick - now);
      end else begin
        elapsed = 64'(TIMER_MAX) - 64'(now) + 64'(vel_ref_tick);
      end
      if (elapsed == 0 || elapsed > 64'(cfg_max_int)) begin
        elapsed               = (cfg_fallback == 0) ? 64'd1 : 64'(cfg_fallback);
        res.interval_fallback = 1'b1;
      end
      unwrap_angle(raw);
      delta = longint'(position_now()) - longint'(vel_ref_pos);
      mag   = (delta < 0) ? 64'(-delta) : 64'(delta);
      k     = 64'(cfg_tpu) * 64'(TICKS_SCALE);
      q     = mag / elapsed;
      r     = mag % elapsed;
      if (k != 0 && q >= 64'h8000_0000) begin
        speed = 64'h8000_0000;
      end else begin
        speed = q * k + (r * k) / elapsed;
        if (speed > 64'h8000_0000) speed = 64'h8000_0000;
      end
      if (delta < 0) begin
        res.velocity = 32'(64'd0 - speed);
      end else begin
        if (speed > 64'h7FFF_FFFF) speed = 64'h7FFF_FFFF;
        res.velocity = speed[31:0];
      end
      res.velocity_valid = 1'b1;
      vel_ref_pos        = position_now();
      vel_ref_tick       = now;
    end else begin
      unwrap_angle(raw);
    end
    res.turn_count = turn_total;
    res.position   = position_now();
    return res;
  endfunction

  // Offers one input word, with an occasional gap before it, and books its result once the
  // block has taken it. It starts and ends on a falling edge, leaving valid high, so that
  // back-to-back words keep valid asserted without a drop.
  task automatic send_word(input logic [1:0] op, input logic [14:0] raw, input logic [23:0] stamp);
    if (idle_on && $urandom_range(99) < 32) begin
      in_ch.valid = 1'b0;
      repeat (($urandom_range(99) < 15) ? $urandom_range(5, 48) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_ch.opcode    = op;
    in_ch.raw_angle = raw;
    in_ch.tick_time = stamp;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    results_due.push_back(track_sample(op, raw, stamp));
    @(negedge clk);
  endtask

  // Stops offering words until every owed result has come back and the block has had time
  // to settle.
  task automatic pause_until_drained();
    in_ch.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      CFG_WRAP_THRESHOLD:    cfg_wrap     = data[14:0];
      CFG_TICKS_PER_US:      cfg_tpu      = data[7:0];
      CFG_MAX_INTERVAL:      cfg_max_int  = data[23:0];
      CFG_FALLBACK_INTERVAL: cfg_fallback = data[23:0];
      default: ;
    endcase
  endtask

  // Registers are only ever changed once the block has gone quiet.
  task automatic apply_settings(input logic [14:0] thr, input logic [7:0] tpu,
                                input logic [23:0] maxi, input logic [23:0] fb);
    pause_until_drained();
    write_reg(CFG_WRAP_THRESHOLD, 24'(thr));
    write_reg(CFG_TICKS_PER_US, 24'(tpu));
    write_reg(CFG_MAX_INTERVAL, maxi);
    write_reg(CFG_FALLBACK_INTERVAL, fb);
  endtask

  // Random words: mostly a shaft turning at a steady pace with a falling timestamp, now and
  // then a fresh init, and a share of words with every field drawn at random.
  task automatic run_random_words(input int count);
    int         kind;
    int         step;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 4) begin
        trk_angle = 15'($urandom);
        trk_stamp = 24'($urandom);
        send_word(OP_INIT, trk_angle, trk_stamp);
      end else if (kind < 14) begin
        send_word(2'($urandom), 15'($urandom), 24'($urandom));
      end else begin
        step      = int'($urandom_range(0, 2 * trk_step_max)) - trk_step_max;
        trk_angle = trk_angle + 15'(step);
        trk_stamp = trk_stamp - 24'($urandom_range(1, trk_dt_max));
        op        = (kind < 60) ? OP_VEL : ((kind < 96) ? OP_ANGLE : OP_SPARE);
        send_word(op, trk_angle, trk_stamp);
      end
    end
  endtask

  // Turn counting at the reset settings: wraps both ways, jumps that sit exactly on the
  // threshold, and the spare opcode behaving as an angle word.
  task automatic test_default_unwrap();
    send_word(OP_INIT, 15'd0, 24'd0);
    send_word(OP_ANGLE, 15'd32767, 24'd0);
    send_word(OP_ANGLE, 15'd0, 24'd0);
    send_word(OP_ANGLE, 15'd26214, 24'd0);
    send_word(OP_ANGLE, 15'd0, 24'd0);
    send_word(OP_ANGLE, 15'd26215, 24'd0);
    send_word(OP_SPARE, 15'd0, TIMER_MAX);
  endtask

  // Interval rules of the down-counter: a zero interval, an ordinary one, equal stamps
  // (a whole timer period), one exactly at the limit, one beyond it, and one across the
  // roll-over of the counter.
  task automatic test_interval_rules();
    send_word(OP_INIT, 15'd1000, 24'd12345);
    send_word(OP_VEL, 15'd1100, TIMER_MAX);
    send_word(OP_VEL, 15'd1200, TIMER_MAX - 24'd9000);
    send_word(OP_VEL, 15'd1300, TIMER_MAX - 24'd9000);
    send_word(OP_VEL, 15'd1250, TIMER_MAX - 24'd4509000);
    send_word(OP_VEL, 15'd1250, 24'd500);
    send_word(OP_VEL, 15'd900, 24'hFFFFF0);
  endtask

  // Register extremes: a zero threshold so that every step wraps, the fastest tick rate
  // with a one-tick interval to drive the velocity into both limits, a zero fallback,
  // a zero tick rate, a zero interval limit and the largest threshold.
  task automatic test_register_extremes();
    apply_settings(15'd0, 8'd255, TIMER_MAX, 24'd0);
    send_word(OP_INIT, 15'd0, 24'd0);
    send_word(OP_VEL, 15'd0, TIMER_MAX);
    send_word(OP_ANGLE, 15'd1, 24'd0);
    send_word(OP_VEL, 15'd2, 24'hFFFFFE);
    send_word(OP_VEL, 15'd0, 24'hFFFFFD);
    apply_settings(15'd0, 8'd0, TIMER_MAX, 24'd0);
    send_word(OP_VEL, 15'd5, 24'hFFFFFC);
    apply_settings(15'd32767, 8'd0, 24'd0, 24'd0);
    send_word(OP_VEL, 15'd32767, 24'hFFFFF0);
    send_word(OP_ANGLE, 15'd0, 24'd0);
    apply_settings(15'd32767, 8'd255, 24'd1, TIMER_MAX);
    send_word(OP_VEL, 15'd100, 24'hFFFFEF);
    send_word(OP_VEL, 15'd200, 24'd0);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the queue fills
  // and the block stalls its input; then everything must come out intact and in order.
  task automatic test_output_backpressure();
    apply_settings(15'd20000, 8'd9, 24'd4500000, 24'd9000);
    trk_step_max      = 3000;
    trk_dt_max        = 20000;
    hold_ready_cycles = 300;
    run_random_words(24);
  endtask

  // The sender stops until every owed result has arrived, then carries on from the same
  // tracker state.
  task automatic test_sender_pause();
    trk_step_max = 300;
    trk_dt_max   = 5000;
    run_random_words(12);
    pause_until_drained();
    run_random_words(12);
  endtask

  // Several phases, each with its own register settings, extremes among them.
  task automatic test_random_traffic();
    logic [14:0] thr;
    logic [7:0]  tpu;
    logic [23:0] maxi;
    logic [23:0] fb;
    for (int phase = 0; phase < 6; phase++) begin
      thr  = ($urandom_range(99) < 20) ? (($urandom_range(1) != 0) ? 15'd32767 : 15'd0)
                                       : 15'($urandom_range(8192, 32767));
      tpu  = ($urandom_range(99) < 10) ? 8'd0 :
             (($urandom_range(99) < 15) ? 8'd255 : 8'($urandom_range(1, 255)));
      maxi = ($urandom_range(99) < 15) ? TIMER_MAX :
             (($urandom_range(99) < 10) ? 24'd0 : 24'($urandom_range(20000, 24'hFFFFFF)));
      fb   = ($urandom_range(99) < 10) ? 24'd0 :
             (($urandom_range(99) < 15) ? TIMER_MAX : 24'($urandom_range(1, 100000)));
      apply_settings(thr, tpu, maxi, fb);
      case ($urandom_range(3))
        0: trk_step_max = 4;
        1: trk_step_max = 300;
        2: trk_step_max = 3000;
        default: trk_step_max = 15000;
      endcase
      case ($urandom_range(3))
        0: trk_dt_max = 50;
        1: trk_dt_max = 5000;
        2: trk_dt_max = 200000;
        default: trk_dt_max = 3000000;
      endcase
      run_random_words(125);
    end
  endtask

  // A long stretch with neither side idling, back at the reset settings.
  task automatic test_burst_traffic();
    apply_settings(WRAP_THRESHOLD_RST, TICKS_PER_US_RST, MAX_INTERVAL_RST, FALLBACK_INTERVAL_RST);
    idle_on      = 1'b0;
    trk_step_max = 3000;
    trk_dt_max   = 20000;
    run_random_words(150);
    idle_on = 1'b1;
  endtask

  // The receiver: ready changes on the falling edge, either held low for a requested
  // stretch, held high during a burst, or dropped at random.
  initial begin : drive_ready
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ready_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_ready_cycles--;
      end else if (!idle_on) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 32);
      end
    end
  end

  // Every result word that the block hands over is checked against the oldest one owed.
  always @(posedge clk) begin : check_results
    tracker_result_t got;
    tracker_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{turn_count: out_ch.turn_count, position: out_ch.position,
              velocity: out_ch.velocity, velocity_valid: out_ch.velocity_valid,
              interval_fallback: out_ch.interval_fallback};
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word %0d arrived with none owed", $time, words_seen);
          $display("  actual   turns %0d pos %0d vel %0d valid %0b fallback %0b",
                   got.turn_count, got.position, got.velocity, got.velocity_valid,
                   got.interval_fallback);
        end
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word %0d differs", $time, words_seen);
            $display("  expected turns %0d pos %0d vel %0d valid %0b fallback %0b",
                     want.turn_count, want.position, want.velocity, want.velocity_valid,
                     want.interval_fallback);
            $display("  actual   turns %0d pos %0d vel %0d valid %0b fallback %0b",
                     got.turn_count, got.position, got.velocity, got.velocity_valid,
                     got.interval_fallback);
          end
        end
      end
      words_seen++;
    end
  end

  // Gives up if no word moves on either channel for far longer than any correct stall.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : run_tests
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_INIT;
    in_ch.raw_angle = '0;
    in_ch.tick_time = '0;

    cfg_wrap     = WRAP_THRESHOLD_RST;
    cfg_tpu      = TICKS_PER_US_RST;
    cfg_max_int  = MAX_INTERVAL_RST;
    cfg_fallback = FALLBACK_INTERVAL_RST;
    last_angle   = '0;
    turn_total   = 0;
    vel_ref_pos  = '0;
    vel_ref_tick = '0;
    trk_angle    = '0;
    trk_stamp    = '0;
    trk_step_max = 300;
    trk_dt_max   = 5000;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_unwrap();
    test_interval_rules();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    test_burst_traffic();

    pause_until_drained();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
